[design/counter_alarm_engine_core_macros.svh]
// Assertion macros for the counter alarm engine.
`ifndef COUNTER_ALARM_ENGINE_CORE_MACROS_SVH
`define COUNTER_ALARM_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CAE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define CAE_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CAE_ASSERT(lbl, clk, rst_n, prop)
`define CAE_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[design/cae_pkg.sv]
// Shared types, constants and command codes for the counter alarm engine.
package cae_pkg;
  localparam int unsigned NumCountersDef = 4;
  localparam int unsigned NumAlarmsDef = 8;
  localparam int unsigned TickBitsDef = 32;
  localparam int unsigned RegW = 32;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_ELAPSED = 2'd3;

  typedef struct packed {
    logic load;      // capture input item
    logic bump;      // advance the addressed counter
    logic wr_alarm;  // write alarm entry
    logic scan_step; // examine current alarm, advance index
    logic fire_upd;  // reschedule the fired alarm
    logic mod_start; // start remainder unit
    logic mod_sel;   // 0 reduce reference or rescheduled sum, 1 reduce current
    logic mod_ref_ld;
    logic el_calc;
    logic out_load;  // present a result
    logic out_fired;
    logic out_last;
  } cae_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic bad;
    logic hit;       // current alarm fires
    logic scan_end;  // current alarm is the last index
    logic need_mod;  // rescheduled sum exceeds maximum
    logic mod_busy;
    logic any_fired;
  } cae_sts_t;
endpackage

[design/cae_mod.sv]
// Restoring remainder unit: one quotient bit per cycle.
module cae_mod import cae_pkg::*; #(
  parameter int unsigned W = TickBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W:0]   num_i,
  input  logic [W:0]   den_i,
  output logic         busy_o,
  output logic [W:0]   rem_o
);
  localparam int unsigned CW = $clog2(W + 2);
  logic [W:0] num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [W+1:0] trial;

  always_comb begin
    num_d = num_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, num_q[W]};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0;
      cnt_d = CW'(W + 1); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) rem_d = W'(trial - {1'b0, den_q}) + (W+1)'(0);
      else rem_d = trial[W:0];
      num_d = {num_q[W-1:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o = rem_q;
endmodule

[design/cae_datapath.sv]
// Datapath: counters, alarm table, remainder unit and result register.
module cae_datapath import cae_pkg::*; #(
  parameter int unsigned NUM_COUNTERS = NumCountersDef,
  parameter int unsigned NUM_ALARMS = NumAlarmsDef,
  parameter int unsigned TICK_BITS = TickBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [RegW-1:0] cfg_data_i,
  input  logic [1:0]      req_type_i,
  input  logic [1:0]      counter_id_i,
  input  logic [2:0]      alarm_id_i,
  input  logic            alarm_enable_i,
  input  logic [31:0]     alarm_expiry_i,
  input  logic [31:0]     alarm_period_i,
  input  logic [31:0]     reference_tick_i,
  input  cae_cmd_t        cmd_i,
  output cae_sts_t        sts_o,
  output logic            status_o,
  output logic [31:0]     current_tick_o,
  output logic [31:0]     max_tick_o,
  output logic [31:0]     elapsed_o,
  output logic [2:0]      fired_alarm_o,
  output logic            fired_o,
  output logic            last_o
);
  localparam int unsigned AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int unsigned TB = TICK_BITS;
  localparam logic [RegW-1:0] TMASK = RegW'((64'd1 << TB) - 64'd1);

  logic [RegW-1:0] max_reg_q [4];
  logic [TB-1:0] tick_q [NUM_COUNTERS];
  logic [NUM_ALARMS-1:0] on_q;
  logic [1:0] acnt_q [NUM_ALARMS];
  logic [TB-1:0] when_q [NUM_ALARMS];
  logic [TB-1:0] cyc_q [NUM_ALARMS];

  logic [1:0] req_q, cid_q;
  logic bad_q;
  logic [2:0] aid_q;
  logic en_q;
  logic [TB-1:0] exp_q, per_q, ref_q, refm_q, cur_q, mx_q;
  logic [AW-1:0] idx_q;
  logic [AW-1:0] pidx_q;
  logic [TB:0] sum_q;
  logic any_q;

  logic [TB-1:0] mx_sel, cur_nxt;
  logic [TB:0] mod_num, mod_rem;
  logic mod_busy;

  always_comb begin
    mx_sel = (max_reg_q[cid_q] > TMASK) ? TB'(TMASK) : TB'(max_reg_q[cid_q]);
  end
  assign cur_nxt = (cur_q >= mx_q) ? '0 : cur_q + 1'b1;

  assign mod_num = cmd_i.mod_sel ? {1'b0, cur_q} : (cmd_i.fire_upd ? sum_q : {1'b0, ref_q});

  cae_mod #(.W(TB)) u_mod (
    .clk_i, .rst_ni, .start_i(cmd_i.mod_start), .num_i(mod_num),
    .den_i({1'b0, mx_q} + 1'b1), .busy_o(mod_busy), .rem_o(mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) max_reg_q[i] <= RegW'(65535);
      for (int i = 0; i < NUM_COUNTERS; i++) tick_q[i] <= '0;
      on_q <= '0;
      any_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (cfg_we_i) max_reg_q[cfg_idx_i] <= cfg_data_i;
      if (cmd_i.load) begin
        idx_q <= '0;
        any_q <= 1'b0;
      end
      if (cmd_i.bump) tick_q[cid_q] <= cur_nxt;
      if (cmd_i.wr_alarm && 32'(aid_q) < NUM_ALARMS) on_q[AW'(aid_q)] <= en_q;
      if (cmd_i.scan_step) begin
        if (sts_o.hit) any_q <= 1'b1;
        if (sts_o.hit && cyc_q[idx_q] == '0) on_q[idx_q] <= 1'b0;
        if (!sts_o.scan_end) idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i; cid_q <= counter_id_i;
      bad_q <= {1'b0, counter_id_i} >= 3'(NUM_COUNTERS);
      aid_q <= alarm_id_i; en_q <= alarm_enable_i;
      exp_q <= TB'(alarm_expiry_i); per_q <= TB'(alarm_period_i);
      ref_q <= TB'(reference_tick_i);
    end
    if (cmd_i.bump) cur_q <= cur_nxt;
    if (cmd_i.mod_ref_ld) begin
      cur_q <= tick_q[NUM_COUNTERS > 1 ? cid_q : 2'd0];
      mx_q <= mx_sel;
    end
    if (cmd_i.load) mx_q <= mx_sel;
    if (cmd_i.wr_alarm && 32'(aid_q) < NUM_ALARMS) begin
      acnt_q[AW'(aid_q)] <= cid_q;
      when_q[AW'(aid_q)] <= exp_q;
      cyc_q[AW'(aid_q)] <= per_q;
    end
    if (cmd_i.scan_step && sts_o.hit) begin
      sum_q <= {1'b0, when_q[idx_q]} + {1'b0, cyc_q[idx_q]};
      pidx_q <= idx_q;
    end
    if (cmd_i.fire_upd && !cmd_i.mod_start) begin
      when_q[pidx_q] <= (sum_q > {1'b0, mx_q}) ? TB'(mod_rem) : TB'(sum_q);
    end
    if (cmd_i.el_calc && cmd_i.mod_start) refm_q <= TB'(mod_rem);
    if (cmd_i.out_load) begin
      status_o <= bad_q;
      current_tick_o <= bad_q ? '0 : 32'(cur_q);
      max_tick_o <= bad_q ? '0 : 32'(mx_q);
      elapsed_o <= (cmd_i.el_calc && cmd_i.mod_sel && !bad_q) ?
        32'((TB'(mod_rem) >= refm_q) ? TB'(mod_rem) - refm_q
            : TB'(({1'b0, mod_rem[TB-1:0]} + {1'b0, mx_q} + 1'b1) - {1'b0, refm_q}))
        : '0;
      fired_o <= cmd_i.out_fired;
      fired_alarm_o <= cmd_i.out_fired ? 3'(pidx_q) : 3'd0;
      last_o <= cmd_i.out_last;
    end
  end

  always_comb begin
    sts_o.req = req_q;
    sts_o.bad = bad_q;
    sts_o.hit = on_q[idx_q] && acnt_q[idx_q] == cid_q && when_q[idx_q] == cur_q;
    sts_o.scan_end = (idx_q == AW'(NUM_ALARMS - 1));
    sts_o.need_mod = sum_q > {1'b0, mx_q};
    sts_o.mod_busy = mod_busy;
    sts_o.any_fired = any_q;
  end
endmodule

[design/cae_ctrl.sv]
// Controller state machine sequencing one item at a time.
module cae_ctrl import cae_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  cae_sts_t sts_i,
  output cae_cmd_t cmd_o
);
`include "counter_alarm_engine_core_macros.svh"
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_TICK = 4'd2, S_SCAN = 4'd3,
    S_FIRE = 4'd4, S_MODW = 4'd5, S_UPD = 4'd6, S_OUT = 4'd7, S_REF = 4'd8,
    S_REFW = 4'd9, S_CURW = 4'd10, S_ELO = 4'd11, S_LAST = 4'd12,
    S_PRE = 4'd14;
  logic [3:0] st_q, st_d;
  logic ov_q, ov_d;
  logic done_q, done_d;

  always_comb begin
    st_d = st_q; ov_d = ov_q; done_d = done_q;
    cmd_o = '0;
    if (ov_q && !out_stall) ov_d = 1'b0;
    case (st_q)
      S_IDLE: if (in_valid) begin
        cmd_o.load = 1'b1; st_d = S_DISP;
      end
      S_DISP: begin
        cmd_o.mod_ref_ld = 1'b1;
        if (sts_i.bad || sts_i.req == REQ_READ) st_d = S_OUT;
        else if (sts_i.req == REQ_WRITE) begin
          cmd_o.wr_alarm = 1'b1; st_d = S_OUT;
        end else if (sts_i.req == REQ_TICK) st_d = S_TICK;
        else st_d = S_REF;
      end
      S_OUT: if (!ov_q || !out_stall) begin
        cmd_o.out_load = 1'b1; cmd_o.out_last = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
      end
      S_TICK: begin
        cmd_o.bump = 1'b1; st_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit) st_d = S_FIRE;
        else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_end) st_d = sts_i.any_fired ? S_LAST : S_OUT;
        end
      end
      S_FIRE: if (!sts_i.any_fired || !ov_q || !out_stall) begin
        if (sts_i.any_fired) begin
          cmd_o.out_load = 1'b1; cmd_o.out_fired = 1'b1; ov_d = 1'b1;
        end
        done_d = sts_i.scan_end;
        cmd_o.scan_step = 1'b1;
        st_d = S_PRE;
      end
      S_PRE: begin
        if (sts_i.need_mod) begin
          cmd_o.fire_upd = 1'b1; cmd_o.mod_start = 1'b1; st_d = S_MODW;
        end else st_d = S_UPD;
      end
      S_MODW: begin
        if (!sts_i.mod_busy) st_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.fire_upd = 1'b1;
        st_d = done_q ? S_LAST : S_SCAN;
      end
      S_LAST: if (!ov_q || !out_stall) begin
        cmd_o.out_load = 1'b1; cmd_o.out_fired = 1'b1; cmd_o.out_last = 1'b1;
        ov_d = 1'b1; st_d = S_IDLE;
      end
      S_REF: begin
        cmd_o.mod_start = 1'b1; st_d = S_REFW;
      end
      S_REFW: if (!sts_i.mod_busy) begin
        cmd_o.el_calc = 1'b1; cmd_o.mod_start = 1'b1; cmd_o.mod_sel = 1'b1; st_d = S_CURW;
      end
      S_CURW: if (!sts_i.mod_busy) st_d = S_ELO;
      S_ELO: if (!ov_q || !out_stall) begin
        cmd_o.el_calc = 1'b1; cmd_o.mod_sel = 1'b1; cmd_o.out_load = 1'b1;
        cmd_o.out_last = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; done_q <= done_d;
    end
  end

  assign in_stall = (st_q != S_IDLE);
  assign out_valid = ov_q;

  `CAE_ASSERT(a_load_idle, clk_i, rst_ni, cmd_o.load |-> st_q == S_IDLE)
  `CAE_ASSERT(a_out_free, clk_i, rst_ni, cmd_o.out_load |-> (!ov_q || !out_stall))
  `CAE_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |=> st_q == S_IDLE || !rst_ni)
endmodule

[design/counter_alarm_engine_core.sv]
// Top level of the counter alarm engine.
// channel | signals                         | direction
// in      | in_valid, in_stall, fields      | consumer
// out     | out_valid, out_stall, fields    | producer
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i | write only
// Elapsed items use two serial remainders. A tick scans every alarm, and each
// reschedule that wraps passes through the serial remainder unit. A stalled output
// holds its result, and the controller waits before loading the next one.
// Reset clears counters, alarm enables, out_valid and the controller; max registers go to 65535.
module counter_alarm_engine_core import cae_pkg::*; #(
  parameter int unsigned NUM_COUNTERS = NumCountersDef,
  parameter int unsigned NUM_ALARMS = NumAlarmsDef,
  parameter int unsigned TICK_BITS = TickBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [RegW-1:0] cfg_data_i,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      req_type_i,
  input  logic [1:0]      counter_id_i,
  input  logic [2:0]      alarm_id_i,
  input  logic            alarm_enable_i,
  input  logic [31:0]     alarm_expiry_i,
  input  logic [31:0]     alarm_period_i,
  input  logic [31:0]     reference_tick_i,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            status_o,
  output logic [31:0]     current_tick_o,
  output logic [31:0]     max_tick_o,
  output logic [31:0]     elapsed_o,
  output logic            fired_o,
  output logic [2:0]      fired_alarm_o,
  output logic            last_o
);
  cae_cmd_t cmd;
  cae_sts_t sts;

  cae_datapath #(.NUM_COUNTERS(NUM_COUNTERS), .NUM_ALARMS(NUM_ALARMS),
                 .TICK_BITS(TICK_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i, .counter_id_i, .alarm_id_i, .alarm_enable_i,
    .alarm_expiry_i, .alarm_period_i, .reference_tick_i,
    .cmd_i(cmd), .sts_o(sts), .status_o, .current_tick_o, .max_tick_o,
    .elapsed_o, .fired_alarm_o, .fired_o, .last_o
  );

  cae_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd)
  );
endmodule

[bench/tb_counter_alarm_engine_core.sv]
// Testbench for the counter alarm engine: random and directed items checked against a predictor.
`timescale 1ns / 100ps
module tb_counter_alarm_engine_core import cae_pkg::*;;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 450;

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  ctr;
    logic [2:0]  aid;
    logic        en;
    logic [31:0] expiry;
    logic [31:0] period;
    logic [31:0] ref_tick;
  } req_item_t;

  typedef struct {
    logic        status;
    logic [31:0] cur;
    logic [31:0] mx;
    logic [31:0] elapsed;
    logic        fired;
    logic [2:0]  idx;
    logic        last;
  } alarm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type_i = '0;
  logic [1:0] counter_id_i = '0;
  logic [2:0] alarm_id_i = '0;
  logic alarm_enable_i = 1'b0;
  logic [31:0] alarm_expiry_i = '0;
  logic [31:0] alarm_period_i = '0;
  logic [31:0] reference_tick_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status_o;
  logic [31:0] current_tick_o;
  logic [31:0] max_tick_o;
  logic [31:0] elapsed_o;
  logic fired_o;
  logic [2:0] fired_alarm_o;
  logic last_o;

  counter_alarm_engine_core dut (.*);

  always #4 clk_i = ~clk_i;

  req_item_t pending_items[$];
  alarm_result_t expected_results[$];
  logic [31:0] max_reg[4];
  logic [31:0] tick_cnt[4];
  logic al_on[8];
  logic [1:0] al_ctr[8];
  logic [31:0] al_when[8];
  logic [31:0] al_cycle[8];
  int errors = 0;
  int checked = 0;
  int fired_seen = 0;
  int accepted = 0;
  int cycles = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;
  int in_gap = 0;
  int out_gap = 0;
  req_item_t cur_item;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic alarm_result_t mk_result(logic [31:0] cur, logic [31:0] mx,
                                              logic [31:0] el, logic fired,
                                              logic [2:0] idx, logic last);
    alarm_result_t r;
    r.status = 1'b0;
    r.cur = cur;
    r.mx = mx;
    r.elapsed = el;
    r.fired = fired;
    r.idx = idx;
    r.last = last;
    return r;
  endfunction

  task automatic predict_alarm_results(input req_item_t it);
    longint unsigned mx, span, cur, t, rr, cr;
    int n;
    mx = max_reg[it.ctr];
    span = mx + 1;
    n = 0;
    case (it.req)
      REQ_TICK: begin
        cur = tick_cnt[it.ctr] + 1;
        if (cur > mx) cur = 0;
        tick_cnt[it.ctr] = cur[31:0];
        for (int i = 0; i < 8; i++) begin
          if (al_on[i] && al_ctr[i] == it.ctr && al_when[i] == cur[31:0]) begin
            expected_results.push_back(mk_result(cur[31:0], mx[31:0], 32'd0, 1'b1, 3'(i),
                                                 1'b0));
            n++;
            if (al_cycle[i] != 0) begin
              t = longint'(al_when[i]) + longint'(al_cycle[i]);
              if (t > mx) t = t % span;
              al_when[i] = t[31:0];
            end else begin
              al_on[i] = 1'b0;
            end
          end
        end
        if (n == 0) begin
          expected_results.push_back(mk_result(cur[31:0], mx[31:0], 32'd0, 1'b0, 3'd0, 1'b1));
        end else expected_results[$].last = 1'b1;
      end
      REQ_WRITE: begin
        al_on[it.aid] = it.en;
        al_ctr[it.aid] = it.ctr;
        al_when[it.aid] = it.expiry;
        al_cycle[it.aid] = it.period;
        expected_results.push_back(mk_result(tick_cnt[it.ctr], mx[31:0], 32'd0, 1'b0, 3'd0,
                                             1'b1));
      end
      REQ_READ: begin
        expected_results.push_back(mk_result(tick_cnt[it.ctr], mx[31:0], 32'd0, 1'b0, 3'd0,
                                             1'b1));
      end
      default: begin
        rr = longint'(it.ref_tick) % span;
        cr = longint'(tick_cnt[it.ctr]) % span;
        t = (cr + span - rr) % span;
        expected_results.push_back(mk_result(tick_cnt[it.ctr], mx[31:0], t[31:0], 1'b0, 3'd0,
                                             1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_alarm_results(cur_item);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          req_type_i <= cur_item.req;
          counter_id_i <= cur_item.ctr;
          alarm_id_i <= cur_item.aid;
          alarm_enable_i <= cur_item.en;
          alarm_expiry_i <= cur_item.expiry;
          alarm_period_i <= cur_item.period;
          reference_tick_i <= cur_item.ref_tick;
          in_valid <= 1'b1;
          in_gap = pick_gap(quiet_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    alarm_result_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end else if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_results.pop_front();
          checked++;
          if (fired_o) fired_seen++;
          if (status_o !== e.status) report_mismatch($sformatf("status %0b exp %0b", status_o, e.status));
          if (current_tick_o !== e.cur)
            report_mismatch($sformatf("current_tick %0h exp %0h", current_tick_o, e.cur));
          if (max_tick_o !== e.mx) report_mismatch($sformatf("max_tick %0h exp %0h", max_tick_o, e.mx));
          if (elapsed_o !== e.elapsed)
            report_mismatch($sformatf("elapsed %0h exp %0h", elapsed_o, e.elapsed));
          if (fired_o !== e.fired) report_mismatch($sformatf("fired %0b exp %0b", fired_o, e.fired));
          if (fired_alarm_o !== e.idx)
            report_mismatch($sformatf("fired_alarm %0d exp %0d", fired_alarm_o, e.idx));
          if (last_o !== e.last) report_mismatch($sformatf("last %0b exp %0b", last_o, e.last));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap(quiet_out);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic set_max(input logic [31:0] m0, input logic [31:0] m1,
                         input logic [31:0] m2, input logic [31:0] m3);
    logic [31:0] vals[4];
    vals = '{m0, m1, m2, m3};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_data_i <= vals[i];
      max_reg[i] = vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_item(input int unsigned req, input int unsigned ctr,
                          input int unsigned aid, input int unsigned en,
                          input logic [31:0] expiry,
                          input logic [31:0] period, input logic [31:0] ref_tick);
    req_item_t it;
    it = '{2'(req), 2'(ctr), 3'(aid), 1'(en), expiry, period, ref_tick};
    pending_items.push_back(it);
  endtask

  task automatic add_random(input int count);
    logic [1:0] c;
    logic [31:0] lim, ex, per;
    int r;
    for (int k = 0; k < count; k++) begin
      c = 2'($urandom_range(3));
      lim = (max_reg[c] > 24) ? 24 : max_reg[c];
      r = $urandom_range(99);
      ex = (r < 80) ? $urandom_range(lim, 0) : $urandom;
      r = $urandom_range(99);
      per = (r < 35) ? 0 : (r < 80) ? $urandom_range(1, 9) : $urandom;
      r = $urandom_range(99);
      if (r < 50) add_item(REQ_TICK, c, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 75) add_item(REQ_WRITE, c, $urandom, ($urandom_range(9) != 0), ex, per, $urandom);
      else if (r < 85) add_item(REQ_READ, c, $urandom, $urandom, $urandom, $urandom, $urandom);
      else add_item(REQ_ELAPSED, c, $urandom, $urandom, $urandom, $urandom,
                    ($urandom_range(1) != 0) ? $urandom : $urandom_range(lim, 0));
    end
  endtask

  task automatic drain;
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      max_reg[i] = 32'd65535;
      tick_cnt[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      al_on[i] = 1'b0;
      al_ctr[i] = '0;
      al_when[i] = '0;
      al_cycle[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: reads, elapsed extremes, one-shot, cyclic, out-of-range expiry
    for (int c = 0; c < 4; c++) add_item(REQ_READ, c, 0, 0, 0, 0, 0);
    add_item(REQ_ELAPSED, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    add_item(REQ_ELAPSED, 1, 7, 1, '1, '1, 32'd65535);
    add_item(REQ_WRITE, 0, 0, 1, 2, 0, 0);
    add_item(REQ_WRITE, 0, 7, 1, 1, 3, 0);
    add_item(REQ_WRITE, 0, 3, 1, 2, 32'hFFFF_FFFF, 0);
    add_item(REQ_WRITE, 1, 5, 1, 32'h0001_0000, 1, 0);
    add_item(REQ_WRITE, 2, 6, 0, 1, 0, 0);
    for (int k = 0; k < 5; k++) add_item(REQ_TICK, 0, 0, 0, 0, 0, 0);
    add_item(REQ_TICK, 1, 0, 0, 0, 0, 0);
    add_item(REQ_TICK, 2, 0, 0, 0, 0, 0);
    add_item(REQ_ELAPSED, 0, 0, 0, 0, 0, 32'd3);
    add_item(REQ_TICK, 3, 0, 0, 0, 0, 0);
    drain();

    quiet_in = 1;
    quiet_out = 1;
    set_max(7, 7, 7, 7);
    add_random(115);
    drain();

    quiet_in = 0;
    set_max(0, 1, 2, 3);
    add_item(REQ_WRITE, 0, 2, 1, 0, 1, 0);
    add_item(REQ_WRITE, 0, 4, 1, 0, 5, 0);
    add_item(REQ_TICK, 0, 0, 0, 0, 0, 0);
    add_random(115);
    drain();

    quiet_out = 0;
    set_max(32'hFFFF_FFFF, 5, 13, 100);
    add_item(REQ_ELAPSED, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    add_random(115);
    drain();

    quiet_in = 1;
    set_max(31, 32'hFFFF_FFFF, 0, 4);
    add_random(115);
    drain();

    $display("covered %0d items, %0d results checked, %0d alarm expiries, 5 max settings",
             accepted, checked, fired_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/cae_pkg.sv
design/cae_mod.sv
design/cae_datapath.sv
design/cae_ctrl.sv
design/counter_alarm_engine_core.sv
bench/tb_counter_alarm_engine_core.sv
